>>> hw/rtl/lrst_pkg.sv
// Package for the lazy range-add / range-sum tree unit.
// Sizes, frame and status types, controller states and datapath op codes.
// No dependencies.
`default_nettype none

package lrst_pkg;

   localparam int MAX_LENGTH = 1024;
   localparam int IDX_W      = $clog2(MAX_LENGTH);
   localparam int LEN_W      = $clog2(MAX_LENGTH + 1);
   localparam int NODES      = 2 * MAX_LENGTH;
   localparam int NODE_W     = $clog2(NODES);
   localparam int SUM_W      = 64;
   localparam int AMT_W      = 32;
   localparam int CSR_W      = 11;
   localparam int STK_D      = IDX_W + 1;
   localparam int STK_AW     = $clog2(STK_D);
   localparam int SP_W       = $clog2(STK_D + 1);

   typedef enum logic [1:0] {
      PH_ENTER,
      PH_RIGHT,
      PH_JOIN
   } phase_type;

   typedef struct packed {
      logic [NODE_W-1:0] v;
      logic [IDX_W-1:0]  lo;
      logic [IDX_W-1:0]  hi;
      phase_type         ph;
   } frame_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_CFG,
      OP_LOAD,
      OP_APPLY_CUR_RD,
      OP_APPLY_L_RD,
      OP_APPLY_R_RD,
      OP_APPLY_WR,
      OP_SUM_RD_CUR,
      OP_ACC,
      OP_PEND_RD,
      OP_PEND_TAKE,
      OP_DESC_L,
      OP_DESC_R,
      OP_JN_RD_L,
      OP_JN_RD_R,
      OP_JN_WR,
      OP_POP
   } op_type;

   typedef struct packed {
      logic      disjoint;
      logic      covered;
      logic      is_add;
      phase_type ph;
      logic      stack_empty;
      logic      pend_zero;
      logic      clear_last;
   } status_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_Q_RD,
      ST_Q_ACC,
      ST_PD_RD,
      ST_PD_TAKE,
      ST_PL_RD,
      ST_PL_WR,
      ST_PR_RD,
      ST_PR_WR,
      ST_DESC_L,
      ST_DESC_R,
      ST_JN_L,
      ST_JN_R,
      ST_JN_WR,
      ST_POP
   } state_type;

   localparam logic ACTION_ADD = 1'b0;

endpackage

`default_nettype wire

>>> hw/rtl/lrst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lrst_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/lrst_ctrl.sv
// Sequencer for the tree walk: one state per memory step.
// Depends on lrst_pkg.
`default_nettype none

module lrst_ctrl
   import lrst_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       csr_valid,
   input  wire status_type status,
   output op_type          op,
   output logic            busy,
   output logic            csr_ready,
   output logic            rsp_strobe
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op         = OP_NONE;
      busy       = 1'b1;
      csr_ready  = 1'b0;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            csr_ready = 1'b1;
            if (csr_valid) begin
               op = OP_CFG;
            end else begin
               op = OP_CLEAR;
               if (status.clear_last) state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // a request word wins; the length write waits until idle with no start
            busy      = 1'b0;
            csr_ready = !start;
            if (start) begin
               op       = OP_LOAD;
               state_in = ST_EVAL;
            end else if (csr_valid) begin
               op       = OP_CFG;
               state_in = ST_CLEAR;
            end
         end
         ST_EVAL: begin
            case (status.ph)
               PH_ENTER: begin
                  if (status.disjoint) state_in = ST_POP;
                  else if (status.covered) state_in = status.is_add ? ST_ADD_RD : ST_Q_RD;
                  else state_in = ST_PD_RD;
               end
               PH_RIGHT: state_in = ST_DESC_R;
               PH_JOIN:  state_in = status.is_add ? ST_JN_L : ST_POP;
               default:  state_in = ST_POP;
            endcase
         end
         ST_ADD_RD: begin
            op = OP_APPLY_CUR_RD;
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            op = OP_APPLY_WR;
            state_in = ST_POP;
         end
         ST_Q_RD: begin
            op = OP_SUM_RD_CUR;
            state_in = ST_Q_ACC;
         end
         ST_Q_ACC: begin
            op = OP_ACC;
            state_in = ST_POP;
         end
         ST_PD_RD: begin
            op = OP_PEND_RD;
            state_in = ST_PD_TAKE;
         end
         ST_PD_TAKE: begin
            op = OP_PEND_TAKE;
            state_in = status.pend_zero ? ST_DESC_L : ST_PL_RD;
         end
         ST_PL_RD: begin
            op = OP_APPLY_L_RD;
            state_in = ST_PL_WR;
         end
         ST_PL_WR: begin
            op = OP_APPLY_WR;
            state_in = ST_PR_RD;
         end
         ST_PR_RD: begin
            op = OP_APPLY_R_RD;
            state_in = ST_PR_WR;
         end
         ST_PR_WR: begin
            op = OP_APPLY_WR;
            state_in = ST_DESC_L;
         end
         ST_DESC_L: begin
            op = OP_DESC_L;
            state_in = ST_EVAL;
         end
         ST_DESC_R: begin
            op = OP_DESC_R;
            state_in = ST_EVAL;
         end
         ST_JN_L: begin
            op = OP_JN_RD_L;
            state_in = ST_JN_R;
         end
         ST_JN_R: begin
            op = OP_JN_RD_R;
            state_in = ST_JN_WR;
         end
         ST_JN_WR: begin
            op = OP_JN_WR;
            state_in = ST_POP;
         end
         ST_POP: begin
            op = OP_POP;
            if (status.stack_empty) begin
               rsp_strobe = !status.is_add;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_EVAL;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/lrst_dp.sv
// Datapath: node-sum and pending-add memories, frame stack, span math,
// multiplier and accumulator. Depends on lrst_pkg and lrst_ram.
`default_nettype none

module lrst_dp
   import lrst_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire op_type            op,
   input  wire logic              req_action,
   input  wire logic [IDX_W-1:0]  req_left_index,
   input  wire logic [IDX_W-1:0]  req_right_index,
   input  wire logic [AMT_W-1:0]  req_add_value,
   input  wire logic [CSR_W-1:0]  csr_active_length,
   output status_type             status,
   output logic      [SUM_W-1:0]  acc
);

   // control registers
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [SP_W-1:0]   sp_ff, sp_in;

   // payload registers
   frame_type         cur_ff, cur_in;
   frame_type         st_ff [STK_D];
   logic              st_we;
   frame_type         st_wd;
   logic [IDX_W-1:0]  l_ff, l_in, r_ff, r_in;
   logic [AMT_W-1:0]  amt_ff, amt_in;
   logic              add_ff, add_in, empty_ff, empty_in;
   logic [SUM_W-1:0]  acc_ff, acc_in, p_ff, p_in, jl_ff, jl_in;
   logic [SUM_W-1:0]  ap_amt_ff, ap_amt_in, prod_ff, prod_in;
   logic [NODE_W-1:0] ap_node_ff, ap_node_in;
   logic              ap_int_ff, ap_int_in;

   // memory ports
   logic              sum_we, pend_we;
   logic [NODE_W-1:0] sum_wa, sel_node;
   logic [IDX_W-1:0]  pend_wa;
   logic [SUM_W-1:0]  sum_wd, pend_wd, sum_rd, pend_rd;

   // span math
   logic [IDX_W:0]    mid_sum;
   logic [IDX_W-1:0]  mid;
   logic [NODE_W-1:0] left_v, right_v;
   logic [LEN_W-1:0]  len_sel, len_clamp;
   logic [SUM_W-1:0]  amt_sel, amt_ext;
   logic [SP_W-1:0]   sp_dec;

   assign mid_sum = {1'b0, cur_ff.lo} + {1'b0, cur_ff.hi};
   assign mid     = mid_sum[IDX_W:1];
   assign left_v  = {cur_ff.v[NODE_W-2:0], 1'b0};
   assign right_v = {cur_ff.v[NODE_W-2:0], 1'b1};
   assign amt_ext = {{(SUM_W-AMT_W){amt_ff[AMT_W-1]}}, amt_ff};
   assign sp_dec  = sp_ff - SP_W'(1);

   always_comb begin
      if (csr_active_length == '0) len_clamp = LEN_W'(1);
      else if (32'(csr_active_length) > MAX_LENGTH) len_clamp = LEN_W'(MAX_LENGTH);
      else len_clamp = LEN_W'(csr_active_length);
   end

   always_comb begin
      case (op)
         OP_APPLY_L_RD, OP_JN_RD_L: begin
            sel_node = left_v;
            len_sel  = LEN_W'(mid) - LEN_W'(cur_ff.lo) + LEN_W'(1);
            amt_sel  = p_ff;
         end
         OP_APPLY_R_RD, OP_JN_RD_R: begin
            sel_node = right_v;
            len_sel  = LEN_W'(cur_ff.hi) - LEN_W'(mid);
            amt_sel  = p_ff;
         end
         default: begin
            sel_node = cur_ff.v;
            len_sel  = LEN_W'(cur_ff.hi) - LEN_W'(cur_ff.lo) + LEN_W'(1);
            amt_sel  = amt_ext;
         end
      endcase
   end

   always_comb begin
      len_in     = len_ff;
      clr_in     = clr_ff;
      sp_in      = sp_ff;
      cur_in     = cur_ff;
      st_we      = 1'b0;
      st_wd      = cur_ff;
      l_in       = l_ff;
      r_in       = r_ff;
      amt_in     = amt_ff;
      add_in     = add_ff;
      empty_in   = empty_ff;
      acc_in     = acc_ff;
      p_in       = p_ff;
      jl_in      = jl_ff;
      ap_amt_in  = ap_amt_ff;
      prod_in    = prod_ff;
      ap_node_in = ap_node_ff;
      ap_int_in  = ap_int_ff;
      sum_we     = 1'b0;
      sum_wa     = cur_ff.v;
      sum_wd     = '0;
      pend_we    = 1'b0;
      pend_wa    = cur_ff.v[IDX_W-1:0];
      pend_wd    = '0;
      case (op)
         OP_CLEAR: begin
            clr_in  = clr_ff + NODE_W'(1);
            sum_we  = 1'b1;
            sum_wa  = clr_ff;
            pend_we = 1'b1;
            pend_wa = clr_ff[IDX_W-1:0];
         end
         OP_CFG: begin
            len_in = len_clamp;
            clr_in = '0;
         end
         OP_LOAD: begin
            cur_in.v  = NODE_W'(1);
            cur_in.lo = '0;
            cur_in.hi = IDX_W'(len_ff - LEN_W'(1));
            cur_in.ph = PH_ENTER;
            sp_in     = '0;
            l_in      = req_left_index;
            r_in      = req_right_index;
            amt_in    = req_add_value;
            add_in    = (req_action == ACTION_ADD);
            empty_in  = req_left_index > req_right_index;
            acc_in    = '0;
         end
         OP_APPLY_CUR_RD, OP_APPLY_L_RD, OP_APPLY_R_RD: begin
            ap_node_in = sel_node;
            ap_amt_in  = amt_sel;
            ap_int_in  = (len_sel != LEN_W'(1));
            prod_in    = SUM_W'(amt_sel * SUM_W'(len_sel));
         end
         OP_APPLY_WR: begin
            sum_we  = 1'b1;
            sum_wa  = ap_node_ff;
            sum_wd  = sum_rd + prod_ff;
            pend_we = ap_int_ff;
            pend_wa = ap_node_ff[IDX_W-1:0];
            pend_wd = pend_rd + ap_amt_ff;
         end
         OP_ACC: acc_in = acc_ff + sum_rd;
         OP_PEND_TAKE: begin
            p_in    = pend_rd;
            pend_we = 1'b1;
         end
         OP_DESC_L: begin
            st_we     = 1'b1;
            st_wd.ph  = PH_RIGHT;
            sp_in     = sp_ff + SP_W'(1);
            cur_in.v  = left_v;
            cur_in.hi = mid;
            cur_in.ph = PH_ENTER;
         end
         OP_DESC_R: begin
            st_we     = 1'b1;
            st_wd.ph  = PH_JOIN;
            sp_in     = sp_ff + SP_W'(1);
            cur_in.v  = right_v;
            cur_in.lo = mid + IDX_W'(1);
            cur_in.ph = PH_ENTER;
         end
         OP_JN_RD_R: jl_in = sum_rd;
         OP_JN_WR: begin
            sum_we = 1'b1;
            sum_wd = jl_ff + sum_rd;
         end
         OP_POP: begin
            if (sp_ff != '0) begin
               cur_in = st_ff[sp_dec[STK_AW-1:0]];
               sp_in  = sp_dec;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(MAX_LENGTH);
         clr_ff <= '0;
         sp_ff  <= '0;
      end else begin
         len_ff <= len_in;
         clr_ff <= clr_in;
         sp_ff  <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      amt_ff     <= amt_in;
      add_ff     <= add_in;
      empty_ff   <= empty_in;
      acc_ff     <= acc_in;
      p_ff       <= p_in;
      jl_ff      <= jl_in;
      ap_amt_ff  <= ap_amt_in;
      prod_ff    <= prod_in;
      ap_node_ff <= ap_node_in;
      ap_int_ff  <= ap_int_in;
      if (st_we) begin
         st_ff[sp_ff[STK_AW-1:0]] <= st_wd;
      end
   end

   lrst_ram #(.WIDTH(SUM_W), .DEPTH(NODES)) u_sum_ram (
      .clock (clock),
      .we    (sum_we),
      .waddr (sum_wa),
      .wdata (sum_wd),
      .raddr (sel_node),
      .rdata (sum_rd)
   );

   lrst_ram #(.WIDTH(SUM_W), .DEPTH(MAX_LENGTH)) u_pend_ram (
      .clock (clock),
      .we    (pend_we),
      .waddr (pend_wa),
      .wdata (pend_wd),
      .raddr (sel_node[IDX_W-1:0]),
      .rdata (pend_rd)
   );

   assign status.disjoint    = empty_ff || (l_ff > cur_ff.hi) || (r_ff < cur_ff.lo);
   assign status.covered     = (cur_ff.lo >= l_ff) && (cur_ff.hi <= r_ff);
   assign status.is_add      = add_ff;
   assign status.ph          = cur_ff.ph;
   assign status.stack_empty = (sp_ff == '0);
   assign status.pend_zero   = (pend_rd == '0);
   assign status.clear_last  = (clr_ff == NODE_W'(NODES - 1));
   assign acc                = acc_ff;

endmodule

`default_nettype wire

>>> hw/rtl/lazy_range_add_range_sum_tree_unit.sv
// Top level of the lazy range-add / range-sum segment tree unit.
// Depends on lrst_pkg, lrst_ctrl, lrst_dp (which holds two lrst_ram).
//
//   channel   handshake                 payload
//   request   start / busy              req_action, req_left_index,
//                                       req_right_index, req_add_value
//   response  rsp_strobe (one cycle)    rsp_range_sum
//   config    csr_valid / csr_ready     csr_active_length
//
// Words are taken one at a time: busy stays high until the walk is done, so no
// new word is taken before the last is through. The walk steps through the
// shared memories node by node (enter, pending push to both children, descend,
// join), one memory step per state, paced by the single read port of the
// node-sum memory.
// Reset and every length write start a clearing pass over all 2*MAX_LENGTH
// node addresses (2048) of both memories; busy stays high meanwhile.
// In idle a start wins over a length write, which then waits until idle with no start.
// The response cannot be stalled: rsp_strobe is high for exactly one cycle.
`default_nettype none

module lazy_range_add_range_sum_tree_unit
   import lrst_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_action,
   input  wire logic [IDX_W-1:0]  req_left_index,
   input  wire logic [IDX_W-1:0]  req_right_index,
   input  wire logic [AMT_W-1:0]  req_add_value,
   output logic                   rsp_strobe,
   output logic      [SUM_W-1:0]  rsp_range_sum,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CSR_W-1:0]  csr_active_length
);

   op_type     op;
   status_type status;

   // sequencer: issues one datapath op per cycle
   lrst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .csr_valid  (csr_valid),
      .status     (status),
      .op         (op),
      .busy       (busy),
      .csr_ready  (csr_ready),
      .rsp_strobe (rsp_strobe)
   );

   // memories, frame stack and arithmetic; the query sum lands in acc
   lrst_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .req_action        (req_action),
      .req_left_index    (req_left_index),
      .req_right_index   (req_right_index),
      .req_add_value     (req_add_value),
      .csr_active_length (csr_active_length),
      .status            (status),
      .acc               (rsp_range_sum)
   );

endmodule

`default_nettype wire

>>> sim/tb.sv
// Testbench for lazy_range_add_range_sum_tree_unit: directed and random range adds and
// range sums, checked word by word against a flat-array predictor. Depends on lrst_pkg.
`timescale 1ns / 1ps

module tb;
   import lrst_pkg::*;

   localparam logic ACTION_QUERY = ~ACTION_ADD;
   localparam int   SETTLE_CYCLES = 300;   // quiet wait before a drain ends and before the end
   localparam int   STALL_LIMIT   = 30000; // clear pass + slowest word, several times over

   typedef enum logic [1:0] {K_WORD, K_LENGTH, K_DRAIN} work_kind_type;

   typedef struct {
      work_kind_type    kind;
      logic             action;
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic [AMT_W-1:0] amount;
      logic [CSR_W-1:0] length;
      bit               quiet;   // no idle gap after this word
   } work_item_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic             req_action = 1'b0;
   logic [IDX_W-1:0] req_left_index = '0;
   logic [IDX_W-1:0] req_right_index = '0;
   logic [AMT_W-1:0] req_add_value = '0;
   logic             rsp_strobe;
   logic [SUM_W-1:0] rsp_range_sum;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_active_length = '0;

   work_item_type    pending[$];
   logic [SUM_W-1:0] sum_queue[$];
   logic [SUM_W-1:0] pos_value[MAX_LENGTH];
   int               cur_length = MAX_LENGTH;
   int               fail_count = 0;
   int               gap_left = 0;
   int               settle_cnt = 0;
   int               stall_cnt = 0;

   always #5 clock = ~clock;

   lazy_range_add_range_sum_tree_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_left_index(req_left_index),
      .req_right_index(req_right_index), .req_add_value(req_add_value),
      .rsp_strobe(rsp_strobe), .rsp_range_sum(rsp_range_sum),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_active_length(csr_active_length)
   );

   task automatic report(input string what, input logic [SUM_W-1:0] got,
                         input logic [SUM_W-1:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // Flat array view: each position kept directly; the tree gives the same
   // wrapped sums.
   function automatic void clear_positions();
      foreach (pos_value[i]) pos_value[i] = '0;
   endfunction

   function automatic void apply_length(input logic [CSR_W-1:0] raw);
      int len;
      len = raw;
      if (len < 1) len = 1;
      if (len > MAX_LENGTH) len = MAX_LENGTH;
      cur_length = len;
      clear_positions();
   endfunction

   function automatic void predict_word(input work_item_type w);
      logic [SUM_W-1:0] amt;
      logic [SUM_W-1:0] acc;
      int               hi;
      amt = {{(SUM_W-AMT_W){w.amount[AMT_W-1]}}, w.amount};
      acc = '0;
      hi = (w.right > cur_length - 1) ? cur_length - 1 : w.right;
      for (int i = w.left; i <= hi; i++) begin
         if (w.action == ACTION_ADD) pos_value[i] += amt;
         else acc += pos_value[i];
      end
      if (w.action == ACTION_QUERY) sum_queue = {sum_queue, acc};
   endfunction

   // driver: one nonblocking assignment per signal per edge
   always @(posedge clock) begin
      logic          nxt_start;
      logic          nxt_cv;
      work_item_type hd;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         if (start && !busy) begin
            hd = pending.pop_front();
            predict_word(hd);
            if (!hd.quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 14);
         end
         if (csr_valid && csr_ready) begin
            hd = pending.pop_front();
            apply_length(hd.length);
         end
         nxt_start = 1'b0;
         nxt_cv    = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending.size() > 0) begin
            hd = pending[0];
            case (hd.kind)
               K_WORD: begin
                  nxt_start = 1'b1;
                  req_action      <= hd.action;
                  req_left_index  <= hd.left;
                  req_right_index <= hd.right;
                  req_add_value   <= hd.amount;
               end
               K_LENGTH: begin
                  nxt_cv = 1'b1;
                  csr_active_length <= hd.length;
               end
               default: begin
                  // hold off until every sum is back and the block is quiet
                  if (sum_queue.size() == 0 && !busy && !start) begin
                     settle_cnt++;
                     if (settle_cnt >= SETTLE_CYCLES) begin
                        settle_cnt = 0;
                        void'(pending.pop_front());
                     end
                  end
               end
            endcase
         end
         start     <= nxt_start;
         csr_valid <= nxt_cv;
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [SUM_W-1:0] want;
      if (!reset && rsp_strobe) begin
         if (sum_queue.size() == 0) begin
            report("unexpected word", rsp_range_sum, '0);
         end else begin
            want = sum_queue.pop_front();
            if (rsp_range_sum !== want) report("range_sum", rsp_range_sum, want);
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (start && !busy) || (csr_valid && csr_ready) || rsp_strobe) begin
         stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         stall_cnt <= stall_cnt + 1;
      end
   end

   task automatic add_word(input logic act, input int l, input int r,
                           input logic [AMT_W-1:0] amt, input bit q);
      work_item_type w;
      w.kind = K_WORD; w.action = act; w.left = IDX_W'(l); w.right = IDX_W'(r);
      w.amount = amt; w.length = '0; w.quiet = q;
      pending = {pending, w};
   endtask

   task automatic add_drain();
      work_item_type w;
      w.kind = K_DRAIN; w.action = '0; w.left = '0; w.right = '0;
      w.amount = '0; w.length = '0; w.quiet = 1'b1;
      pending = {pending, w};
   endtask

   task automatic add_length(input logic [CSR_W-1:0] len);
      work_item_type w;
      add_drain();
      w.kind = K_LENGTH; w.action = '0; w.left = '0; w.right = '0;
      w.amount = '0; w.length = len; w.quiet = 1'b1;
      pending = {pending, w};
   endtask

   // mostly ranges inside the active length, some anywhere, some empty
   task automatic add_random(input int len, input bit q);
      int l, r, pick;
      logic [AMT_W-1:0] amt;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         l = $urandom_range(0, len - 1);
         r = $urandom_range(l, len - 1);
      end else begin
         l = $urandom_range(0, MAX_LENGTH - 1);
         r = $urandom_range(0, MAX_LENGTH - 1);
      end
      amt = ($urandom_range(0, 2) == 0) ? $urandom : AMT_W'($urandom_range(0, 2000) - 1000);
      add_word($urandom_range(0, 1) ? ACTION_QUERY : ACTION_ADD, l, r, amt, q);
   endtask

   initial begin
      int lens[8];
      int len;
      clear_positions();
      // directed: full length after reset, then small and clamped lengths
      add_word(ACTION_ADD, 0, 1023, 32'h7FFF_FFFF, 0);
      add_word(ACTION_QUERY, 0, 1023, '0, 0);
      add_word(ACTION_ADD, 0, 1023, 32'h8000_0000, 0);
      add_word(ACTION_ADD, 0, 1023, 32'h8000_0000, 0);
      add_word(ACTION_QUERY, 0, 1023, '0, 0);
      add_word(ACTION_ADD, 5, 3, 32'h0000_1234, 0);      // empty range
      add_word(ACTION_QUERY, 7, 2, '0, 0);               // empty range
      add_word(ACTION_ADD, 1023, 1023, 32'hFFFF_FFFF, 0);
      add_word(ACTION_QUERY, 0, 0, '0, 0);
      add_word(ACTION_QUERY, 1023, 1023, '0, 0);
      add_word(ACTION_ADD, 300, 700, 32'h0000_0155, 0);
      add_word(ACTION_QUERY, 512, 1022, 32'hFFFF_FFFF, 0);
      add_drain();                                       // sender waits for every sum
      add_length(11'd3);                                 // ranges past the length
      add_word(ACTION_ADD, 0, 1023, 32'h0000_0007, 0);
      add_word(ACTION_QUERY, 2, 1023, '0, 0);
      add_word(ACTION_QUERY, 3, 5, '0, 0);               // wholly past the length
      add_word(ACTION_ADD, 3, 1023, 32'h0000_0009, 0);
      add_word(ACTION_QUERY, 0, 2, '0, 0);
      add_length(11'd0);                                 // taken as one position
      add_word(ACTION_ADD, 0, 5, 32'h8000_0001, 0);
      add_word(ACTION_QUERY, 0, 0, '0, 0);
      add_length(11'd2047);                              // clamped to full length
      add_word(ACTION_QUERY, 0, 1023, '0, 0);
      lens = '{1, 2, 64, 1000, 1024, 5, 0, 1024};
      lens[6] = $urandom_range(1, 1024);
      for (int p = 0; p < 8; p++) begin
         add_length(CSR_W'(lens[p]));
         len = (lens[p] < 1) ? 1 : lens[p];
         for (int i = 0; i < 130; i++) add_random(len, (p == 4) || (p == 7));
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending.size() == 0 && sum_queue.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
